[hw/rtl/bsps_pkg.sv]
// shared types, codes and the quarter-wave sine table for the phase sweep
package bsps_pkg;

  localparam int ANGLE_W = 9;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 5;
  localparam int ROM_W   = 16;
  localparam int ROMA_W  = 7;
  localparam int PROD_W  = 24;
  localparam int CFG_W   = 9;
  localparam int CFGA_W  = 1;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RESP  = 2'd1,
    OP_NORESP = 2'd2,
    OP_STEER = 2'd3
  } opcode_t;

  localparam logic [CFGA_W-1:0] REG_ANT_COUNT  = 1'b0;
  localparam logic [CFGA_W-1:0] REG_ANGLE_STEP = 1'b1;

  function automatic logic [ROM_W-1:0] sine_q15(input logic [ROMA_W-1:0] idx);
    logic [ROM_W-1:0] v;
    case (idx)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
      7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
      7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
      7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/beam_steering_phase_sweep.sv]
// top level: steering angle sequencer and per-antenna phase emitter
//
//  channel  | signals                               | beat contents
//  ---------+---------------------------------------+------------------------------------
//  in_      | in_tvalid in_tready in_tdata[15:0]    | opcode, angle_deg
//  out_     | out_tvalid out_tready out_tdata out_tlast | antenna_index, phase_deg; last
//  cfg_     | cfg_wr_en cfg_index cfg_wdata[8:0]    | 0 ant_count, 1 angle_step
//
//  an event steps through operand wrap, angle add, angle fold, sine lookup and
//  increment scaling, then emits one antenna per cycle through the shared modular adder
//  while the output side does not stall; the idle state takes the beat of the next
//  event only once the previous event is through
//  a stalled output holds the emitter; in_tready is high only while idle
//  rst_n is synchronous; it clears angle, sequencer, accumulator and output valid and resets the config registers
module beam_steering_phase_sweep import bsps_pkg::*; #(
  parameter int ANT_MAX   = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // opcode[1:0], angle_deg[10:2]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // antenna_index[4:0], phase_deg[13:5]
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFGA_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW = ANGLE_W + FRAC_BITS;
  localparam logic [AW-1:0] MOD_PH = AW'(360) << FRAC_BITS;
  localparam logic [AW-1:0] MOD_AN = AW'(360);
  localparam logic [AW-1:0] MOD_WRAP = AW'(1) << ANGLE_W;
  localparam logic [CNT_W:0] CNT_MAX = (CNT_W+1)'(ANT_MAX);

  typedef enum logic [2:0] {
    S_IDLE, S_WRAP, S_ANGLE, S_FOLD, S_LOOK, S_INC, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  opcode_t            op_r, op_nxt;
  logic [ANGLE_W-1:0] ang_in_r, ang_in_nxt;
  logic [ANGLE_W-1:0] tmp_r, tmp_nxt;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic [CNT_W-1:0]   ant_count_r, ant_count_nxt;
  logic [ANGLE_W-1:0] angle_step_r, angle_step_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]      inc_r, inc_nxt;
  logic [AW-1:0]      acc_r, acc_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [15:0]        odata_r, odata_nxt;
  logic               olast_r, olast_nxt;

  logic [AW-1:0]      add_a, add_b, add_m, add_y;
  logic [PROD_W-1:0]  prod;
  logic               neg;
  logic [PROD_W+FRAC_BITS-1:0] rnd;
  logic [AW-1:0]      mag;
  logic [CNT_W-1:0]   cnt_sat;
  logic               is_last;
  logic               out_free;

  bsps_modadd #(.W(AW)) u_add (
    .a(add_a), .b(add_b), .m(add_m), .y(add_y)
  );

  bsps_sine u_sine (
    .clk(clk), .load(state_r == S_LOOK), .angle(angle_r), .prod(prod), .neg(neg)
  );

  assign rnd     = {prod, FRAC_BITS'(0)} + (PROD_W+FRAC_BITS)'(16384);
  assign mag     = rnd[AW+14:15];
  assign cnt_sat = ({1'b0, ant_count_r} > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : ant_count_r;
  assign is_last = (idx_r + CNT_W'(1)) == cnt_r;
  assign out_free = !ovalid_r || out_tready;

  // operand select for the shared adder
  always_comb begin
    add_a = AW'(tmp_r);
    add_b = '0;
    add_m = MOD_AN;
    unique case (state_r)
      S_WRAP: begin
        add_a = (op_r == OP_STEER) ? AW'(ang_in_r) : AW'(angle_step_r);
      end
      S_ANGLE: begin
        add_a = AW'(angle_r);
        add_b = AW'(tmp_r);
        add_m = MOD_WRAP;
      end
      S_EMIT: begin
        add_a = acc_r;
        add_b = inc_r;
        add_m = MOD_PH;
      end
      default: begin
        add_a = AW'(tmp_r);
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ang_in_nxt     = ang_in_r;
    tmp_nxt        = tmp_r;
    angle_nxt      = angle_r;
    ant_count_nxt  = ant_count_r;
    angle_step_nxt = angle_step_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    inc_nxt        = inc_r;
    acc_nxt        = acc_r;
    ovalid_nxt     = ovalid_r && !out_tready;
    odata_nxt      = odata_r;
    olast_nxt      = olast_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ANT_COUNT:  ant_count_nxt  = cfg_wdata[CNT_W-1:0];
        REG_ANGLE_STEP: angle_step_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = opcode_t'(in_tdata[1:0]);
          ang_in_nxt = in_tdata[10:2];
          state_nxt  = S_WRAP;
        end
      end
      S_WRAP: begin
        tmp_nxt   = add_y[ANGLE_W-1:0];
        state_nxt = S_ANGLE;
      end
      S_ANGLE: begin
        // angle sum keeps its low 9 bits before the fold
        case (op_r)
          OP_START: tmp_nxt = '0;
          OP_STEER: tmp_nxt = tmp_r;
          default:  tmp_nxt = add_y[ANGLE_W-1:0];
        endcase
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        angle_nxt = add_y[ANGLE_W-1:0];
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cnt_nxt   = cnt_sat;
        state_nxt = S_INC;
      end
      S_INC: begin
        if (mag == '0) begin
          inc_nxt = '0;
        end else if (neg) begin
          inc_nxt = MOD_PH - mag;
        end else begin
          inc_nxt = mag;
        end
        acc_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {2'b00, acc_r[AW-1 -: ANGLE_W], idx_r[IDX_W-1:0]};
          olast_nxt  = is_last;
          acc_nxt    = add_y;
          idx_nxt    = idx_r + CNT_W'(1);
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      angle_r      <= '0;
      ant_count_r  <= CNT_W'(32);
      angle_step_r <= ANGLE_W'(10);
      ovalid_r     <= 1'b0;
      acc_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      angle_r      <= angle_nxt;
      ant_count_r  <= ant_count_nxt;
      angle_step_r <= angle_step_nxt;
      ovalid_r     <= ovalid_nxt;
      acc_r        <= acc_nxt;
    end
    op_r     <= op_nxt;
    ang_in_r <= ang_in_nxt;
    tmp_r    <= tmp_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    inc_r    <= inc_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef ASSERT_OFF
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r < DEG_360) else $error("steering angle out of range");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < MOD_PH) else $error("phase accumulator not reduced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output beat changed while stalled");
`endif

endmodule

[hw/rtl/bsps_modadd.sv]
// shared modular adder: (a + b) mod m for a, b below m
module bsps_modadd import bsps_pkg::*; #(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic [W-1:0] y
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = sum - {1'b0, m};
  assign y    = (sum >= {1'b0, m}) ? diff[W-1:0] : sum[W-1:0];

endmodule

[hw/rtl/bsps_sine.sv]
// quadrant fold, sine table lookup and scaling by 180 degrees, registered
module bsps_sine import bsps_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [ANGLE_W-1:0] angle,
  output logic [PROD_W-1:0]  prod,
  output logic               neg
);

  logic [ANGLE_W-1:0] fold;
  logic               neg_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;

  always_comb begin
    fold    = angle;
    neg_nxt = 1'b0;
    if (angle <= DEG_90) begin
      fold = angle;
    end else if (angle <= DEG_180) begin
      fold = DEG_180 - angle;
    end else if (angle <= DEG_270) begin
      fold    = angle - DEG_180;
      neg_nxt = 1'b1;
    end else begin
      fold    = DEG_360 - angle;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(sine_q15(fold[ROMA_W-1:0])) * PROD_W'(180);
      neg_r  <= neg_nxt;
    end
  end

  assign prod = prod_r;
  assign neg  = neg_r;

endmodule

[test/phase_sweep_checker.sv]
// checker: predicts the per-antenna phase beats of each event and compares them with the output
module phase_sweep_checker import bsps_pkg::*; #(
  parameter int ANT_MAX   = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,   // opcode[1:0], angle_deg[10:2]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,  // antenna_index[4:0], phase_deg[13:5]
  input  logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFGA_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_MOD = 360 << FRAC_BITS;

  // round(32768*sin(d)) for d = 0..90
  localparam logic [15:0] SINE_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic [IDX_W-1:0]   antenna;
    logic [ANGLE_W-1:0] phase;
    logic               last;
  } phase_beat_t;

  phase_beat_t        expected_phases [$];
  logic [CNT_W-1:0]   ant_count_q;
  logic [ANGLE_W-1:0] angle_step_q;
  logic [ANGLE_W-1:0] steer_angle;
  int                 fails = 0;

  // keeps the low 9 bits, then folds 360..511 down once
  function automatic logic [ANGLE_W-1:0] fold_angle(input logic [ANGLE_W:0] a);
    logic [ANGLE_W-1:0] v;
    v = a[ANGLE_W-1:0];
    if (v >= DEG_360) v = v - DEG_360;
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    opcode_t           op;
    int unsigned       idx;
    logic              neg;
    longint unsigned   mag;
    int unsigned       inc;
    int unsigned       acc;
    int unsigned       count;
    int                i;
    phase_beat_t       beat_e;
    if (!rst_n) begin
      ant_count_q  = 6'd32;
      angle_step_q = 9'd10;
      steer_angle  = '0;
      expected_phases.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_ANT_COUNT) ant_count_q = cfg_wdata[CNT_W-1:0];
        else if (cfg_index == REG_ANGLE_STEP) angle_step_q = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        op = opcode_t'(in_tdata[1:0]);
        case (op)
          OP_START: steer_angle = '0;
          OP_STEER: steer_angle = fold_angle({1'b0, in_tdata[10:2]});
          default: begin
            steer_angle = fold_angle({1'b0, steer_angle} +
                                     {1'b0, fold_angle({1'b0, angle_step_q})});
          end
        endcase
        // quarter-wave lookup with sign by quadrant
        neg = 1'b0;
        if (steer_angle <= DEG_90) begin
          idx = 32'(steer_angle);
        end else if (steer_angle <= DEG_180) begin
          idx = 32'(DEG_180 - steer_angle);
        end else if (steer_angle <= DEG_270) begin
          idx = 32'(steer_angle - DEG_180);
          neg = 1'b1;
        end else begin
          idx = 32'(DEG_360 - steer_angle);
          neg = 1'b1;
        end
        if (idx > 90) idx = 90;
        mag = (((64'd180 * SINE_Q15[idx]) << FRAC_BITS) + 64'd16384) >> 15;
        if (mag >= 64'(PHASE_MOD)) mag = 64'(PHASE_MOD - 1);
        if (mag == 0) inc = 0;
        else if (neg) inc = PHASE_MOD - int'(mag);
        else inc = int'(mag);
        count = (32'(ant_count_q) > 32'(ANT_MAX)) ? 32'(ANT_MAX) : 32'(ant_count_q);
        acc = 0;
        for (i = 0; i < count; i++) begin
          beat_e.antenna = i[IDX_W-1:0];
          beat_e.phase   = ANGLE_W'(acc >> FRAC_BITS);
          beat_e.last    = (i + 1 == count);
          expected_phases.push_back(beat_e);
          acc = acc + inc;
          if (acc >= PHASE_MOD) acc = acc - PHASE_MOD;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_phases.size() == 0) begin
          $display("%0t: unexpected beat antenna_index %0d phase_deg %0d last %0b",
                   $time, out_tdata[4:0], out_tdata[13:5], out_tlast);
          fails++;
        end else begin
          beat_e = expected_phases.pop_front();
          if (out_tdata[4:0] !== beat_e.antenna) begin
            $display("%0t: antenna_index expected %0d actual %0d",
                     $time, beat_e.antenna, out_tdata[4:0]);
            fails++;
          end
          if (out_tdata[13:5] !== beat_e.phase) begin
            $display("%0t: phase_deg of antenna %0d expected %0d actual %0d",
                     $time, beat_e.antenna, beat_e.phase, out_tdata[13:5]);
            fails++;
          end
          if (out_tlast !== beat_e.last) begin
            $display("%0t: last of antenna %0d expected %0b actual %0b",
                     $time, beat_e.antenna, beat_e.last, out_tlast);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_phases.size();
  end

endmodule

[test/tb_top.sv]
// testbench top: drives events, configuration and output back-pressure, reports the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bsps_pkg::*;

  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASES        = 10;
  localparam int PHASE_EVENTS  = 50;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;   // opcode[1:0], angle_deg[10:2]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;       // antenna_index[4:0], phase_deg[13:5]
  logic              out_tlast;
  logic              cfg_wr_en = 1'b0;
  logic [CFGA_W-1:0] cfg_index = REG_ANT_COUNT;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  int                fail_count;
  int                pending;
  bit                quiet = 1'b0;
  bit                long_hold_req = 1'b0;

  beam_steering_phase_sweep u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  phase_sweep_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_event(input opcode_t op, input logic [ANGLE_W-1:0] ang);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, ang, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all expected beats, then let a possibly silent event finish
  task automatic settle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] cnt_word, input logic [CFG_W-1:0] step);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ANT_COUNT;
    cfg_wdata <= cnt_word;
    @(posedge clk);
    cfg_index <= REG_ANGLE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // output back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int                 phase;
    int                 n;
    int                 seq_left;
    int                 pick;
    opcode_t            op;
    logic [ANGLE_W-1:0] ang;
    logic [CFG_W-1:0]   cnt_word;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 32 antennas, 10 degree step
    send_event(OP_START, 9'd0);
    send_event(OP_RESP, 9'd511);
    send_event(OP_NORESP, 9'd0);
    send_event(OP_STEER, 9'd90);
    send_event(OP_STEER, 9'd180);
    send_event(OP_STEER, 9'd270);
    send_event(OP_STEER, 9'd359);
    send_event(OP_STEER, 9'd360);
    send_event(OP_STEER, 9'd511);
    send_event(OP_STEER, 9'd30);
    send_event(OP_STEER, 9'd300);
    send_event(OP_START, 9'd359);
    settle;

    // single antenna, largest in-range step, angle sum past 511
    set_config(9'd1, 9'd359);
    send_event(OP_RESP, 9'd0);
    send_event(OP_STEER, 9'd350);
    send_event(OP_NORESP, 9'd170);
    send_event(OP_START, 9'd0);
    settle;

    // zero antennas: angle moves, nothing comes out
    set_config(9'b111_000000, 9'd511);
    send_event(OP_RESP, 9'd0);
    send_event(OP_STEER, 9'd200);
    settle;

    // count above the array size saturates, zero step
    set_config(9'd63, 9'd0);
    send_event(OP_RESP, 9'd0);
    send_event(OP_STEER, 9'd1);
    settle;

    set_config(9'd33, 9'd360);
    send_event(OP_NORESP, 9'd0);
    send_event(OP_RESP, 9'd0);
    settle;

    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase >= PHASES - 2);
      cnt_word = CFG_W'($urandom_range(0, 511));
      if ($urandom_range(0, 7) == 0) cnt_word[CNT_W-1:0] = CNT_W'($urandom_range(0, 63));
      else cnt_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 32));
      set_config(cnt_word, CFG_W'($urandom_range(0, 511)));
      if (phase == 3) long_hold_req = 1'b1;
      seq_left = 0;
      for (n = 0; n < PHASE_EVENTS; n++) begin
        ang = ANGLE_W'($urandom_range(0, 359));
        if ($urandom_range(0, 4) == 0) ang = ANGLE_W'($urandom_range(360, 511));
        if (seq_left == 0) begin
          seq_left = $urandom_range(3, 15);
          op = OP_START;
        end else begin
          seq_left--;
          pick = $urandom_range(0, 19);
          if (pick < 14) op = pick[0] ? OP_RESP : OP_NORESP;
          else if (pick < 17) op = OP_STEER;
          else op = opcode_t'($urandom_range(0, 3));
        end
        if (op != OP_STEER && $urandom_range(0, 1) == 0) ang = '0;
        send_event(op, ang);
      end
      settle;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
